>>> sv/wma_crossover_signal_assert.svh
// assertion macros shared by the crossover block
// both sample on i_clk and are switched off while i_rst_n is low
`ifndef WMA_CROSSOVER_SIGNAL_ASSERT_SVH
`define WMA_CROSSOVER_SIGNAL_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define WCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold at a later cycle than the antecedent
`define WCS_ASSERT_TWO(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

>>> sv/wcs_pkg.sv
`default_nettype none

package wcs_pkg;

    localparam int PRICE_W   = 24;
    localparam int QTY_W     = 24;
    localparam int AVG_W     = 32;
    localparam int WS_W      = 7;
    localparam int FRAC_BITS = 8;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [WS_W-1:0] WS_RESET = 7'd16;
    localparam int REG_WINDOW_SIZE = 0;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } t_signal;

    typedef struct packed {
        logic [PRICE_W-1:0] tick_price;
        logic [QTY_W-1:0]   tick_quantity;
    } t_in_item;

    // decision part of a result, fixed before the average is divided out
    typedef struct packed {
        t_signal            signal;
        logic [QTY_W-1:0]   order_quantity;
        logic [PRICE_W-1:0] order_price;
    } t_order;

    typedef struct packed {
        t_signal            signal;
        logic [QTY_W-1:0]   order_quantity;
        logic [PRICE_W-1:0] order_price;
        logic [AVG_W-1:0]   average_value;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

>>> sv/wcs_queue.sv
`default_nettype none

module wcs_queue
    import wcs_pkg::*;
#(
    parameter int DEPTH  = 2,
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_push_data,
    input  wire logic              i_pop,
    output logic      [DATA_W-1:0] o_pop_data,
    output t_q_stat                o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_pop_data   = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

>>> sv/wcs_front.sv
`default_nettype none

module wcs_front
    import wcs_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 24,
    parameter int JOB_W      = 93
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire t_in_item                               i_in_item,
    input  wire logic                                   i_cfg_wr,
    input  wire logic [$clog2(MAX_WINDOW + 1)-1:0]      i_eff_new,
    input  wire logic [$clog2(MAX_WINDOW + 1)-1:0]      i_eff_size,
    input  wire t_q_stat                                i_q_stat,
    output logic                                        o_push,
    output logic      [JOB_W-1:0]                       o_job
);

    localparam int SW   = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int DMAX = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
    localparam int DW   = $clog2(DMAX + 1);
    localparam int WW   = SW + DW;
    localparam int PSW  = SW + CW;
    localparam int NW   = 2 * CW + 1;

    typedef struct packed {
        t_order          order;
        logic [WW-1:0]   wsum;
        logic [CW-1:0]   fill;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_TRIM,
        F_UPD,
        F_FIN
    } t_fstate;

    t_fstate          r_state;
    logic [CW-1:0]    r_fill;
    logic [CW-1:0]    r_keep;
    logic [AW-1:0]    r_oldest;
    logic [WW-1:0]    r_wsum;
    logic [PSW-1:0]   r_psum;
    logic [SW-1:0]    r_last;
    logic [SW-1:0]    r_price;
    logic [QTY_W-1:0] r_qty;
    logic             r_full;
    logic [DW-1:0]    r_d;
    logic [WW-1:0]    r_wadd;
    logic [WW-1:0]    r_wbase;
    logic [WW-1:0]    r_last_d;
    logic [WW-1:0]    r_new_d;
    logic [SW-1:0]    r_rd;
    logic [SW-1:0]    r_mem [MAX_WINDOW];

    logic [NW-1:0]    w_nn;
    logic [CW-1:0]    w_weight;
    logic [AW:0]      w_slot_sum;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_oldest_inc;
    logic [WW-1:0]    w_wnew;
    t_signal          w_sig;
    logic             w_accept;
    t_job             w_job;

    assign w_nn       = NW'(i_eff_size) * (NW'(i_eff_size) + NW'(1));
    assign w_weight   = r_full ? r_fill : r_fill + CW'(1);
    assign w_slot_sum = {1'b0, r_oldest} + (AW + 1)'(r_fill);
    assign w_wr_addr  = (w_slot_sum >= (AW + 1)'(MAX_WINDOW))
                      ? AW'(w_slot_sum - (AW + 1)'(MAX_WINDOW)) : AW'(w_slot_sum);
    assign w_oldest_inc = (r_oldest == AW'(MAX_WINDOW - 1)) ? '0 : r_oldest + AW'(1);
    assign w_wnew     = r_wbase + r_wadd;

    // crossover only once the window was already full
    always_comb begin
        w_sig = SIG_NONE;
        if (r_full) begin
            if ((r_last_d < r_wsum) && (r_new_d > w_wnew)) begin
                w_sig = SIG_BUY;
            end else if ((r_last_d > r_wsum) && (r_new_d < w_wnew)) begin
                w_sig = SIG_SELL;
            end
        end
    end

    assign o_in_ready = (r_state == F_IDLE) && (r_fill == r_keep) && !i_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_job.order.signal         = w_sig;
        w_job.order.order_quantity = (w_sig != SIG_NONE) ? r_qty : '0;
        w_job.order.order_price    = (w_sig != SIG_NONE) ? PRICE_W'(r_price) : '0;
        w_job.wsum                 = w_wnew;
        w_job.fill                 = r_fill;
    end

    assign o_push = (r_state == F_FIN);
    assign o_job  = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_fill   <= '0;
            r_keep   <= '0;
            r_oldest <= '0;
            r_wsum   <= '0;
            r_psum   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (r_fill > r_keep) begin
                        r_state <= F_TRIM;
                    end else if (w_accept) begin
                        r_price <= i_in_item.tick_price[SW-1:0];
                        r_qty   <= i_in_item.tick_quantity;
                        r_full  <= (r_fill == i_eff_size);
                        r_d     <= DW'(w_nn >> 1);
                        r_state <= F_UPD;
                    end
                end
                F_TRIM: begin
                    r_wsum   <= r_wsum - WW'(r_psum);
                    r_psum   <= r_psum - PSW'(r_rd);
                    r_oldest <= w_oldest_inc;
                    r_fill   <= r_fill - CW'(1);
                    r_state  <= F_IDLE;
                end
                F_UPD: begin
                    r_wadd   <= WW'(r_price) * WW'(w_weight);
                    r_last_d <= WW'(r_last) * WW'(r_d);
                    r_new_d  <= WW'(r_price) * WW'(r_d);
                    r_wbase  <= r_full ? r_wsum - WW'(r_psum) : r_wsum;
                    r_psum   <= r_psum - (r_full ? PSW'(r_rd) : '0) + PSW'(r_price);
                    if (r_full) begin
                        r_oldest <= w_oldest_inc;
                    end else begin
                        r_fill <= r_fill + CW'(1);
                    end
                    r_state <= F_FIN;
                end
                F_FIN: begin
                    r_wsum  <= w_wnew;
                    r_last  <= r_price;
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
            // a smaller window only ever lowers the level to trim down to
            if (i_cfg_wr && (i_eff_new < r_keep)) begin
                r_keep <= i_eff_new;
            end else if (r_state == F_FIN) begin
                r_keep <= r_fill;
            end
        end
    end

    // price ring, oldest entry read every cycle
    always_ff @(posedge i_clk) begin
        if (r_state == F_UPD) begin
            r_mem[w_wr_addr] <= r_price;
        end
        r_rd <= r_mem[r_oldest];
    end

endmodule

`default_nettype wire

>>> sv/wcs_back.sv
`default_nettype none

module wcs_back
    import wcs_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 24,
    parameter int JOB_W      = 93
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_q_stat           i_q_stat,
    input  wire logic [JOB_W-1:0]  i_job_data,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item
);

    localparam int SW   = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int DMAX = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
    localparam int DW   = $clog2(DMAX + 1);
    localparam int WW   = SW + DW;
    localparam int QW   = WW + FRAC_BITS;
    localparam int CTW  = $clog2(QW);
    localparam int NW   = 2 * CW + 1;

    typedef struct packed {
        t_order          order;
        logic [WW-1:0]   wsum;
        logic [CW-1:0]   fill;
    } t_job;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_HOLD
    } t_bstate;

    t_bstate          r_state;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_order           r_order;
    logic [QW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CTW-1:0]   r_cnt;

    t_job             w_job;
    logic [NW-1:0]    w_kk;
    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_ge;
    logic             w_load;

    assign w_job   = i_job_data;
    assign w_kk    = NW'(w_job.fill) * (NW'(w_job.fill) + NW'(1));
    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    // result register free, or emptied at this edge
    assign w_load  = (r_state == B_HOLD) && (!r_out_valid || i_out_ready);

    assign o_pop       = (r_state == B_IDLE) && !i_q_stat.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_order <= w_job.order;
                        r_quo   <= {w_job.wsum, FRAC_BITS'(0)};
                        r_rem   <= '0;
                        r_den   <= DW'(w_kk >> 1);
                        r_cnt   <= '0;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem <= w_ge ? DW'(w_diff) : DW'(w_trial);
                    r_quo <= {r_quo[QW-2:0], w_ge};
                    if (r_cnt == CTW'(QW - 1)) begin
                        r_state <= B_HOLD;
                    end else begin
                        r_cnt <= r_cnt + CTW'(1);
                    end
                end
                B_HOLD: begin
                    if (w_load) begin
                        r_out_item.signal         <= r_order.signal;
                        r_out_item.order_quantity <= r_order.order_quantity;
                        r_out_item.order_price    <= r_order.order_price;
                        r_out_item.average_value  <= AVG_W'(r_quo);
                        r_state                   <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/wma_crossover_signal.sv
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------
// input     | i_in_valid / o_in_ready    | i_in_item  (price, quantity)
// result    | o_out_valid / i_out_ready  | o_out_item (signal, order, average)
// config    | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
// front: per item, oldest price read from the ring, sum update (F_UPD), crossover compare
//   (F_FIN), then one pass through F_TRIM per price dropped when the window is shrunk
// back: restoring divider for the 24.8 average, one quotient bit per cycle; it pops the
//   next item only after the last result has been loaded into the result register
// reset: synchronous, active low; window empty, window_size back to 16
// stalls: a 2-entry queue parts front and back; a held result stalls back, then front
`default_nettype none
`include "wma_crossover_signal_assert.svh"

module wma_crossover_signal
    import wcs_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 24
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    // item in
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_item,
    // item out
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_item
);

    localparam int SW    = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int DMAX  = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
    localparam int DW    = $clog2(DMAX + 1);
    localparam int WW    = SW + DW;
    localparam int JOB_W = $bits(t_order) + WW + CW;
    localparam int Q_DEPTH = 2;

    logic [WS_W-1:0]  r_window_size;

    logic             w_reg_hit;
    logic             w_cfg_wr;
    logic [CW-1:0]    w_eff_new;
    logic [CW-1:0]    w_eff_size;
    logic             w_push;
    logic [JOB_W-1:0] w_job;
    logic             w_pop;
    logic [JOB_W-1:0] w_pop_data;
    t_q_stat          w_q_stat;

    // zero acts as a window of one, anything above the ring depth as full depth
    function automatic logic [CW-1:0] f_eff(input logic [WS_W-1:0] ws);
        logic [CW-1:0] v;
        if (ws == '0) begin
            v = CW'(1);
        end else if (int'(ws) > MAX_WINDOW) begin
            v = CW'(MAX_WINDOW);
        end else begin
            v = CW'(ws);
        end
        return v;
    endfunction

    // register file: window_size only, at byte address 0
    assign w_reg_hit = (paddr[APB_AW-1:2] == (APB_AW - 2)'(REG_WINDOW_SIZE));
    assign w_cfg_wr  = psel && penable && pwrite && w_reg_hit;
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? APB_DW'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_RESET;
        end else if (w_cfg_wr) begin
            r_window_size <= pwdata[WS_W-1:0];
        end
    end

    assign w_eff_new  = f_eff(pwdata[WS_W-1:0]);
    assign w_eff_size = f_eff(r_window_size);

    // front: ring, sums and crossover decision
    wcs_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg_wr   (w_cfg_wr),
        .i_eff_new  (w_eff_new),
        .i_eff_size (w_eff_size),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    // decided items waiting for the divider
    wcs_queue #(
        .DEPTH  (Q_DEPTH),
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_job),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    // back: average division and result register
    wcs_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_job_data  (w_pop_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // every accepted item reaches the queue, pushed once the front reaches F_FIN
    `WCS_ASSERT_TWO(a_accept_pushes, i_in_valid && o_in_ready, w_push, "item lost in front")
    // the front never writes into a full queue
    `WCS_ASSERT_SAME(a_push_room, w_push, !w_q_stat.full, "push into full queue")
    // a result without a crossover carries no order
    `WCS_ASSERT_SAME(a_no_sig_no_order, o_out_valid && (o_out_item.signal == SIG_NONE),
        (o_out_item.order_quantity == '0) && (o_out_item.order_price == '0),
        "order fields set without signal")

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wcs_pkg::*;

    typedef longint unsigned u64;

    // a tick waiting to be offered, optionally held back until the block has drained
    typedef struct {
        t_in_item tick;
        bit       drain_first;
    } t_tick_req;

    localparam int MAX_WIN      = 64;
    localparam int PRICE_MAX    = (1 << PRICE_W) - 1;
    localparam int QTY_MAX      = (1 << QTY_W) - 1;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int WATCHDOG_MAX = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_TICKS = 1450;
    localparam int STEADY_PHASE = 6;
    localparam int PAUSE_PHASE  = 3;

    localparam logic [APB_AW-1:0] WS_ADDR    = APB_AW'(4 * REG_WINDOW_SIZE);
    localparam logic [APB_AW-1:0] SPARE_ADDR = APB_AW'(4 * (REG_WINDOW_SIZE + 1));

    // clock, reset and every block input start at known values
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_item   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_item;

    // stimulus bookkeeping
    t_tick_req tick_backlog[$];
    t_out_item awaited_items[$];
    int        ticks_queued = 0;
    int        ticks_taken  = 0;
    int        mismatches   = 0;
    bit        steady       = 1'b0;

    // receiver hold-off and watchdog state
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // shadow of the block: price ring, fill level, oldest slot and the register
    logic [PRICE_W-1:0] ring_prices [MAX_WIN];
    int unsigned        ring_count  = 0;
    int unsigned        ring_oldest = 0;
    logic [WS_W-1:0]    ws_reg      = WS_RESET;

    wma_crossover_signal #(
        .MAX_WINDOW (MAX_WIN),
        .PRICE_BITS (PRICE_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow model of the window and the crossover decision
    // ------------------------------------------------------------------

    // register value of zero behaves as one, anything past the ring depth as the depth
    function automatic int unsigned live_span();
        int unsigned n;
        n = ws_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_WIN)
            n = MAX_WIN;
        return n;
    endfunction

    // oldest price has weight one, newest has weight equal to the fill level
    function automatic u64 weighted_total();
        u64 acc;
        acc = 0;
        for (int unsigned i = 0; i < ring_count; i++)
            acc += u64'(ring_prices[(ring_oldest + i) % MAX_WIN]) * u64'(i + 1);
        return acc;
    endfunction

    function automatic void drop_oldest_price();
        if (ring_count == 0)
            return;
        ring_oldest = (ring_oldest + 1) % MAX_WIN;
        ring_count--;
    endfunction

    function automatic void shrink_to_span();
        while (ring_count > live_span())
            drop_oldest_price();
    endfunction

    function automatic void append_price(logic [PRICE_W-1:0] price);
        ring_prices[(ring_oldest + ring_count) % MAX_WIN] = price;
        ring_count++;
    endfunction

    // only the window size register exists, other addresses are ignored
    function automatic void apply_reg_write(logic [APB_AW-1:0] addr,
                                            logic [APB_DW-1:0] data);
        if ((addr >> 2) != REG_WINDOW_SIZE)
            return;
        ws_reg = data[WS_W-1:0];
        shrink_to_span();
    endfunction

    // one tick in, one order decision plus the 24.8 weighted average out
    function automatic t_out_item crossover_result(t_in_item tick);
        t_out_item   res;
        int unsigned n;
        u64          d;
        u64          old_w;
        u64          new_w;
        u64          last_d;
        u64          new_d;
        u64          q;
        u64          r;
        res = '0;
        n = live_span();
        shrink_to_span();
        if (ring_count < n) begin
            // still filling: append only, never a signal
            append_price(tick.tick_price);
        end else begin
            // compare against the averages scaled by n(n+1)/2, so no rounding
            d      = u64'(n) * u64'(n + 1) / 2;
            last_d = u64'(ring_prices[(ring_oldest + ring_count - 1) % MAX_WIN]) * d;
            old_w  = weighted_total();
            new_d  = u64'(tick.tick_price) * d;
            drop_oldest_price();
            append_price(tick.tick_price);
            new_w = weighted_total();
            // a price equal to an average is no crossover
            if (last_d < old_w && new_d > new_w)
                res.signal = SIG_BUY;
            else if (last_d > old_w && new_d < new_w)
                res.signal = SIG_SELL;
        end
        if (res.signal != SIG_NONE) begin
            res.order_quantity = tick.tick_quantity;
            res.order_price    = tick.tick_price;
        end
        // average over the current fill level, truncated and cut to the field
        d     = u64'(ring_count) * u64'(ring_count + 1) / 2;
        new_w = weighted_total();
        q     = new_w / d;
        r     = new_w % d;
        res.average_value = AVG_W'((q << FRAC_BITS) + ((r << FRAC_BITS) / d));
        return res;
    endfunction

    function automatic void check_field(string field, u64 want, u64 got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // sender: offers ticks from the backlog, predicts on every accepted item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tick_req next_req;
        logic      busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_items.insert(awaited_items.size(), crossover_result(i_in_item));
                ticks_taken <= ticks_taken + 1;
            end
            // an offered item stays put until it is taken
            busy = i_in_valid && !o_in_ready;
            if (!busy) begin
                if (tick_backlog.size() != 0
                        && !(tick_backlog[0].drain_first && awaited_items.size() != 0)
                        && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    next_req = tick_backlog[0];
                    tick_backlog.delete(0);
                    i_in_valid <= 1'b1;
                    i_in_item  <= next_req.tick;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random back-pressure plus one long hold-off so the block fills up
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && ticks_taken >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // result checker: each accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_items.size() == 0) begin
                $error("result with no item outstanding: %h", o_out_item);
                mismatches++;
            end else begin
                want = awaited_items[0];
                awaited_items.delete(0);
                check_field("signal", want.signal, o_out_item.signal);
                check_field("order_quantity", want.order_quantity, o_out_item.order_quantity);
                check_field("order_price", want.order_price, o_out_item.order_price);
                check_field("average_value", want.average_value, o_out_item.average_value);
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_tick(input int price, input int qty, input bit drain_first = 1'b0);
        t_tick_req req;
        req.tick.tick_price    = PRICE_W'(price);
        req.tick.tick_quantity = QTY_W'(qty);
        req.drain_first        = drain_first;
        tick_backlog.insert(tick_backlog.size(), req);
        ticks_queued++;
    endtask

    // waits until every item is taken and every result is back
    task automatic wait_idle();
        while (ticks_taken != ticks_queued || awaited_items.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write (setup then access), then read the window size back
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_reg_write(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        paddr   <= WS_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("window_size", ws_reg, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // price shapes in segments: oscillation to force crossovers, random walk,
    // flat runs for ties, and raw noise across the full range
    task automatic queue_ticks(input int count, input int pause_at);
        int kind;
        int base;
        int amp;
        int half;
        int walk;
        int price;
        int seg_left;
        kind     = 0;
        base     = 0;
        amp      = 1;
        half     = 1;
        walk     = 0;
        seg_left = 0;
        for (int i = 0; i < count; i++) begin
            if (seg_left == 0) begin
                kind = $urandom_range(9);
                case ($urandom_range(3))
                    0: base = 0;
                    1: base = PRICE_MAX;
                    default: base = $urandom_range(PRICE_MAX);
                endcase
                amp      = $urandom_range(1, 5000);
                half     = $urandom_range(1, 8);
                walk     = base;
                seg_left = $urandom_range(15, 60);
            end
            seg_left--;
            if (kind <= 4) begin
                price = ((i / half) % 2) ? base + amp : base - amp;
                price += int'($urandom_range(amp / 4));
            end else if (kind <= 6) begin
                walk += int'($urandom_range(2 * amp)) - amp;
                if (walk < 0)
                    walk = 0;
                if (walk > PRICE_MAX)
                    walk = PRICE_MAX;
                price = walk;
            end else if (kind == 7) begin
                price = base;
            end else begin
                price = int'($urandom() & PRICE_MAX);
            end
            if (price < 0)
                price = 0;
            if (price > PRICE_MAX)
                price = PRICE_MAX;
            add_tick(price, int'($urandom() & QTY_MAX), i == pause_at);
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int ws_plan[$];
        int phase;
        int random_total;
        int count;
        int ws;
        ws_plan = '{64, 3, 1, 0, 127, 2, 64, 16, 5};
        phase        = 0;
        random_total = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // default window of sixteen: filling only, extremes of both fields
        add_tick(0, QTY_MAX);
        add_tick(PRICE_MAX, 0);
        wait_idle();

        // window of two: full-scale swings give a buy then a sell, flat prices give ties
        write_reg(WS_ADDR, 2);
        add_tick(PRICE_MAX, 1);
        add_tick(0, QTY_MAX);
        add_tick(PRICE_MAX, 12345);
        add_tick(0, 54321);
        add_tick(100, 7);
        add_tick(100, 8);
        add_tick(100, 9);
        wait_idle();

        // window of one never signals; a zero register acts as one
        write_reg(WS_ADDR, 1);
        add_tick(5, 1);
        add_tick(PRICE_MAX, 2);
        add_tick(0, 3);
        wait_idle();
        write_reg(WS_ADDR, 0);
        add_tick(7, 4);
        add_tick(1, 5);
        wait_idle();

        // oversized register saturates at the ring depth
        write_reg(WS_ADDR, 32'hFFFF_FF7F);
        add_tick(200, 6);
        add_tick(300, 7);
        add_tick(100, 8);
        wait_idle();

        // write to a non-existent register must leave everything alone
        write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
        add_tick(PRICE_MAX, QTY_MAX);
        add_tick(0, 0);
        wait_idle();

        // random phases, each under its own window size; shrinking phases
        // drop the oldest prices at the register write
        while (random_total < RANDOM_TICKS) begin
            ws = (phase < ws_plan.size()) ? ws_plan[phase] : $urandom_range(127);
            if ($urandom_range(3) == 0)
                write_reg(SPARE_ADDR, $urandom());
            write_reg(WS_ADDR, ($urandom() & ~32'h7F) | ws);
            steady = (phase == STEADY_PHASE);
            count  = $urandom_range(80, 130);
            // one phase has a tick held back until everything is out
            queue_ticks(count, (phase == PAUSE_PHASE) ? count / 2 : -1);
            random_total += count;
            wait_idle();
            steady = 1'b0;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_items.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/wcs_pkg.sv
sv/wcs_queue.sv
sv/wcs_front.sv
sv/wcs_back.sv
sv/wma_crossover_signal.sv
sim/tb_top.sv
